// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check at each clock edge, skipped while reset is held
`define NWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check at each clock edge, reset included
`define NWS_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NWS_ASSERT(lbl, prop, msg)
`define NWS_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/nws_pkg.sv -----
`default_nettype none

package nws_pkg;

    // Fixed-point constants: 1.0 is 2^62
    localparam logic signed [63:0] Q_ONE     = 64'sh4000_0000_0000_0000;
    localparam logic        [63:0] Q_ONE_U   = 64'h4000_0000_0000_0000;
    localparam logic signed [64:0] Q_ONE_W   = 65'sh0_4000_0000_0000_0000;
    localparam logic        [63:0] PI_Q62    = 64'hC90F_DAA2_2168_C235;
    // One full turn in degrees * 2^23, and twice that
    localparam logic        [32:0] FULL_TURN = 33'd3019898880;
    localparam logic signed [34:0] TWO_TURN  = 35'sd6039797760;
    localparam logic        [8:0]  PHASE_DIV = 9'd45;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_FOUND = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Where a finished sine/cosine pair goes
    typedef enum logic [1:0] {
        RET_QUERY,
        RET_POINT,
        RET_DIFF
    } ret_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_OUT,
        S_RD,
        S_CHK,
        S_M1,
        S_M1W,
        S_M2,
        S_M2W,
        S_M3,
        S_M3W,
        S_CMP,
        S_SC_MOD,
        S_SC_PH,
        S_SC_PHW,
        S_SC_TW,
        S_SC_T2W,
        S_SC_PM,
        S_SC_PMW,
        S_SC_PDW,
        S_SC_SN,
        S_SC_SNW
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [8:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

    // Sine series divisor 2k(2k+1)
    function automatic logic [8:0] sin_div(input logic [3:0] k);
        logic [8:0] d;
        case (k)
            4'd1:    d = 9'd6;
            4'd2:    d = 9'd20;
            4'd3:    d = 9'd42;
            4'd4:    d = 9'd72;
            4'd5:    d = 9'd110;
            4'd6:    d = 9'd156;
            4'd7:    d = 9'd210;
            4'd8:    d = 9'd272;
            4'd9:    d = 9'd342;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

    // Cosine series divisor (2k-1)2k
    function automatic logic [8:0] cos_div(input logic [3:0] k);
        logic [8:0] d;
        case (k)
            4'd1:    d = 9'd2;
            4'd2:    d = 9'd12;
            4'd3:    d = 9'd30;
            4'd4:    d = 9'd56;
            4'd5:    d = 9'd90;
            4'd6:    d = 9'd132;
            4'd7:    d = 9'd182;
            4'd8:    d = 9'd240;
            4'd9:    d = 9'd306;
            4'd10:   d = 9'd380;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nws_mul.sv -----
`default_nettype none

// 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
module nws_mul
    import nws_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic [63:0]  a_reg, b_reg;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   psh_reg, psh_next;
    logic         pv_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;

    // Select the partial product for this cycle
    always_comb
    begin
        case (cnt_reg)
            3'd0:
            begin
                pp_next  = a_reg[31:0] * b_reg[31:0];
                psh_next = 2'd0;
            end
            3'd1:
            begin
                pp_next  = a_reg[31:0] * b_reg[63:32];
                psh_next = 2'd1;
            end
            3'd2:
            begin
                pp_next  = a_reg[63:32] * b_reg[31:0];
                psh_next = 2'd1;
            end
            default:
            begin
                pp_next  = a_reg[63:32] * b_reg[63:32];
                psh_next = 2'd2;
            end
        endcase
    end

    // Accumulate the previous partial product at its weight
    always_comb
    begin
        acc_next = acc_reg;
        if (pv_reg)
        begin
            case (psh_reg)
                2'd0:    acc_next = acc_reg + {64'd0, pp_reg};
                2'd1:    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
                default: acc_next = acc_reg + {pp_reg, 64'd0};
            endcase
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            pv_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                pv_reg  <= (cnt_reg < 3'd4);
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            pp_reg  <= pp_next;
            psh_reg <= psh_next;
            acc_reg <= acc_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nws_div.sv -----
`default_nettype none

// Divides a 64-bit word by a small divisor, eight quotient bits a cycle.
module nws_div
    import nws_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [63:0] num_reg, quot_reg;
    logic [8:0]  rem_reg, den_reg;
    logic [2:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [8:0]  rem_next;
    logic [7:0]  qbits;

    // Eight restoring steps on the narrow remainder
    always_comb
    begin
        logic [9:0] trial;
        rem_next = rem_reg;
        qbits    = 8'd0;
        for (int n = 0; n < 8; n++)
        begin
            trial = {rem_next, num_reg[63 - n]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next      = 9'(trial - {1'b0, den_reg});
                qbits[7 - n]  = 1'b1;
            end
            else
            begin
                rem_next = trial[8:0];
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.dividend;
            den_reg  <= req.divisor;
            rem_reg  <= 9'd0;
            quot_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[55:0], 8'd0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[55:0], qbits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_waypoint_search.sv -----
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: latitude, longitude
// m_axis    out        tuser: status;  tdata: nearest_index
//
// Add, clear and no-op words go from S_DECODE straight back to S_IDLE; a
// dropped add and an empty query first wait in S_OUT for the output register.
// A query first takes the sine and cosine of its own latitude, then walks all N
// stored waypoints (a waypoint equal to the query skips the trigonometry). Each
// other point needs two sine/cosine series, worked on the shared multiplier
// (four partial products) and the shared divider (8 quotient bits a cycle).
// One word is worked on at a time; a finished result waits in the output
// register while the next word is taken. Reset empties the table at once.
`default_nettype none

`include "assert_macros.svh"

module nearest_waypoint_search
    import nws_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [30:0] latitude, [62:31] longitude
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [9:0] nearest_index
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    state_t   state_reg, state_next;
    ret_t     ret_reg, ret_next;
    cmd_t     cmd_reg;
    logic [30:0] lat_reg;
    logic [31:0] lon_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] i_reg, i_next, best_i_reg, best_i_next;
    logic signed [63:0] best_k_reg, best_k_next, kval_reg, kval_next;
    logic signed [33:0] x_reg, x_next;
    logic [32:0] r_reg, r_next;
    logic [1:0]  quad_reg, quad_next;
    logic        swap_reg, swap_next;
    logic [63:0] t_reg, t_next, t2_reg, t2_next, acc_reg, acc_next, s_reg, s_next;
    logic [3:0]  term_reg, term_next;
    logic        cos_reg, cos_next;
    logic signed [63:0] sq_reg, sq_next, cq_reg, cq_next, sp_reg, sp_next;
    logic signed [63:0] cp_reg, cp_next, sd_reg, sd_next, cd_reg, cd_next;
    logic signed [63:0] t1_reg, t1_next, u_reg, u_next;
    logic [9:0]  res_index_reg, res_index_next;
    status_t     res_status_reg, res_status_next;
    logic        out_valid_reg;
    logic [9:0]  out_index_reg;
    status_t     out_status_reg;
    logic        out_load;

    logic [62:0] mem [MAX_POINTS];
    logic [62:0] rd_q_reg;
    logic        mem_wr_en, mem_rd_en;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    nws_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
    nws_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic [30:0] plat;
    logic [31:0] plon;
    logic [63:0] prod_q62;
    logic [31:0] phase;
    logic [29:0] fold;
    logic [31:0] r_red;
    logic [63:0] sa, ca;
    logic signed [63:0] sn_out, cs_out;
    logic signed [63:0] t2_val;
    logic signed [64:0] ksum;
    logic        take_new;
    logic [IDX_W-1:0] best_i_upd;
    logic [IDX_W+9:0] idx_pad;
    logic        last_point;

    assign plat     = rd_q_reg[30:0];
    assign plon     = rd_q_reg[62:31];
    assign prod_q62 = mul_rsp.prod[125:62];
    assign phase    = div_rsp.quot[31:0];
    assign r_red    = (r_reg >= FULL_TURN) ? 32'(r_reg - FULL_TURN) : r_reg[31:0];

    // Fold the phase into the first octant
    always_comb
    begin
        if (!phase[29])
            fold = phase[29:0];
        else
            fold = 30'(31'h4000_0000 - {1'b0, phase[29:0]});
    end

    // Quadrant and octant symmetry
    always_comb
    begin
        sa = swap_reg ? acc_reg : prod_q62;
        ca = swap_reg ? prod_q62 : acc_reg;
        case (quad_reg)
            2'd0:
            begin
                sn_out = $signed(sa);
                cs_out = $signed(ca);
            end
            2'd1:
            begin
                sn_out = $signed(ca);
                cs_out = -$signed(sa);
            end
            2'd2:
            begin
                sn_out = -$signed(sa);
                cs_out = -$signed(ca);
            end
            default:
            begin
                sn_out = -$signed(ca);
                cs_out = $signed(sa);
            end
        endcase
    end

    // Signed second term and the sign-extended sum of both terms
    assign t2_val     = signed_of(prod_q62, u_reg[63] ^ cd_reg[63]);
    assign ksum       = {t1_reg[63], t1_reg} + {t2_val[63], t2_val};
    assign take_new   = (i_reg == '0) || (kval_reg > best_k_reg);
    assign best_i_upd = take_new ? i_reg : best_i_reg;
    assign idx_pad    = {10'd0, best_i_upd};
    assign last_point = ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg);
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // Sequencer: next state and unit requests
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        best_i_next     = best_i_reg;
        best_k_next     = best_k_reg;
        kval_next       = kval_reg;
        x_next          = x_reg;
        r_next          = r_reg;
        quad_next       = quad_reg;
        swap_next       = swap_reg;
        t_next          = t_reg;
        t2_next         = t2_reg;
        acc_next        = acc_reg;
        s_next          = s_reg;
        term_next       = term_reg;
        cos_next        = cos_reg;
        sq_next         = sq_reg;
        cq_next         = cq_reg;
        sp_next         = sp_reg;
        cp_next         = cp_reg;
        sd_next         = sd_reg;
        cd_next         = cd_reg;
        t1_next         = t1_reg;
        u_next          = u_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mul_req         = '0;
        div_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_DECODE;
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg < CNT_W'(MAX_POINTS))
                        begin
                            mem_wr_en  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            res_index_next  = 10'd0;
                            res_status_next = STAT_FULL;
                            state_next      = S_OUT;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    CMD_QUERY:
                    begin
                        if (count_reg == '0)
                        begin
                            res_index_next  = 10'd0;
                            res_status_next = STAT_EMPTY;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            i_next     = '0;
                            x_next     = {{3{lat_reg[30]}}, lat_reg};
                            ret_next   = RET_QUERY;
                            state_next = S_SC_MOD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            // Fetch the next stored waypoint
            S_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (plat == lat_reg && plon == lon_reg)
                begin
                    kval_next  = Q_ONE;
                    state_next = S_CMP;
                end
                else
                begin
                    x_next     = {{3{plat[30]}}, plat};
                    ret_next   = RET_POINT;
                    state_next = S_SC_MOD;
                end
            end

            // sin(lat_p) * sin(lat_q)
            S_M1:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = abs64(sp_reg);
                mul_req.b     = abs64(sq_reg);
                state_next    = S_M1W;
            end

            S_M1W:
            begin
                if (mul_rsp.done)
                begin
                    t1_next    = signed_of(prod_q62, sp_reg[63] ^ sq_reg[63]);
                    state_next = S_M2;
                end
            end

            // cos(lat_p) * cos(lat_q)
            S_M2:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = abs64(cp_reg);
                mul_req.b     = abs64(cq_reg);
                state_next    = S_M2W;
            end

            S_M2W:
            begin
                if (mul_rsp.done)
                begin
                    u_next     = signed_of(prod_q62, cp_reg[63] ^ cq_reg[63]);
                    state_next = S_M3;
                end
            end

            // times cos(dlon), then sum and clamp
            S_M3:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = abs64(u_reg);
                mul_req.b     = abs64(cd_reg);
                state_next    = S_M3W;
            end

            S_M3W:
            begin
                if (mul_rsp.done)
                begin
                    if (ksum > Q_ONE_W)
                        kval_next = Q_ONE;
                    else if (ksum < -Q_ONE_W)
                        kval_next = -Q_ONE;
                    else
                        kval_next = ksum[63:0];
                    state_next = S_CMP;
                end
            end

            // Keep the best so far, lower index wins ties
            S_CMP:
            begin
                best_i_next = best_i_upd;
                if (take_new)
                    best_k_next = kval_reg;
                if (last_point)
                begin
                    res_index_next  = idx_pad[9:0];
                    res_status_next = STAT_FOUND;
                    state_next      = S_OUT;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_RD;
                end
            end

            // Reduce the angle into one turn
            S_SC_MOD:
            begin
                if (x_reg[33])
                    r_next = 33'({x_reg[33], x_reg} + TWO_TURN);
                else
                    r_next = 33'(x_reg);
                state_next = S_SC_PH;
            end

            // Phase = r * 64 / 45
            S_SC_PH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {26'd0, r_red, 6'd0};
                div_req.divisor  = PHASE_DIV;
                state_next       = S_SC_PHW;
            end

            S_SC_PHW:
            begin
                if (div_rsp.done)
                begin
                    quad_next     = phase[31:30];
                    swap_next     = phase[29];
                    mul_req.start = 1'b1;
                    mul_req.a     = {34'd0, fold};
                    mul_req.b     = PI_Q62;
                    state_next    = S_SC_TW;
                end
            end

            S_SC_TW:
            begin
                if (mul_rsp.done)
                begin
                    t_next        = mul_rsp.prod[94:31];
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.prod[94:31];
                    mul_req.b     = mul_rsp.prod[94:31];
                    state_next    = S_SC_T2W;
                end
            end

            S_SC_T2W:
            begin
                if (mul_rsp.done)
                begin
                    t2_next    = prod_q62;
                    acc_next   = Q_ONE_U;
                    term_next  = 4'd9;
                    cos_next   = 1'b0;
                    state_next = S_SC_PM;
                end
            end

            // Horner step: acc = 1 - t2 * acc / d
            S_SC_PM:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = t2_reg;
                mul_req.b     = acc_reg;
                state_next    = S_SC_PMW;
            end

            S_SC_PMW:
            begin
                if (mul_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_q62;
                    div_req.divisor  = cos_reg ? cos_div(term_reg) : sin_div(term_reg);
                    state_next       = S_SC_PDW;
                end
            end

            S_SC_PDW:
            begin
                if (div_rsp.done)
                begin
                    if (term_reg == 4'd1)
                    begin
                        if (!cos_reg)
                        begin
                            s_next     = Q_ONE_U - div_rsp.quot;
                            acc_next   = Q_ONE_U;
                            term_next  = 4'd10;
                            cos_next   = 1'b1;
                            state_next = S_SC_PM;
                        end
                        else
                        begin
                            acc_next   = Q_ONE_U - div_rsp.quot;
                            state_next = S_SC_SN;
                        end
                    end
                    else
                    begin
                        acc_next   = Q_ONE_U - div_rsp.quot;
                        term_next  = term_reg - 4'd1;
                        state_next = S_SC_PM;
                    end
                end
            end

            S_SC_SN:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = t_reg;
                mul_req.b     = s_reg;
                state_next    = S_SC_SNW;
            end

            // Map to the full angle and hand back
            S_SC_SNW:
            begin
                if (mul_rsp.done)
                begin
                    case (ret_reg)
                        RET_QUERY:
                        begin
                            sq_next    = sn_out;
                            cq_next    = cs_out;
                            state_next = S_RD;
                        end
                        RET_POINT:
                        begin
                            sp_next    = sn_out;
                            cp_next    = cs_out;
                            x_next     = 34'({{2{plon[31]}}, plon} - {{2{lon_reg[31]}}, lon_reg});
                            ret_next   = RET_DIFF;
                            state_next = S_SC_MOD;
                        end
                        default:
                        begin
                            sd_next    = sn_out;
                            cd_next    = cs_out;
                            state_next = S_M1;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= cmd_t'(s_axis_tuser);
            lat_reg <= s_axis_tdata[30:0];
            lon_reg <= s_axis_tdata[62:31];
        end
        ret_reg        <= ret_next;
        i_reg          <= i_next;
        best_i_reg     <= best_i_next;
        best_k_reg     <= best_k_next;
        kval_reg       <= kval_next;
        x_reg          <= x_next;
        r_reg          <= r_next;
        quad_reg       <= quad_next;
        swap_reg       <= swap_next;
        t_reg          <= t_next;
        t2_reg         <= t2_next;
        acc_reg        <= acc_next;
        s_reg          <= s_next;
        term_reg       <= term_next;
        cos_reg        <= cos_next;
        sq_reg         <= sq_next;
        cq_reg         <= cq_next;
        sp_reg         <= sp_next;
        cp_reg         <= cp_next;
        sd_reg         <= sd_next;
        cd_reg         <= cd_next;
        t1_reg         <= t1_next;
        u_reg          <= u_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Waypoint table
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[count_reg[IDX_W-1:0]] <= {lon_reg, lat_reg};
        if (mem_rd_en)
            rd_q_reg <= mem[i_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_index_reg};
    assign m_axis_tuser  = out_status_reg;

    `NWS_ASSERT_NR(a_count_bound, count_reg <= CNT_W'(MAX_POINTS), "point count beyond table")
    `NWS_ASSERT(a_wr_room, mem_wr_en |-> count_reg < CNT_W'(MAX_POINTS), "write to full table")
    `NWS_ASSERT(a_mul_free, mul_req.start |-> !mul_rsp.busy, "multiplier started while busy")
    `NWS_ASSERT(a_div_free, div_req.start |-> !div_rsp.busy, "divider started while busy")

endmodule

`default_nettype wire

// ----- verif/nearest_waypoint_search_test.sv -----
`default_nettype none

module nearest_waypoint_search_test
    import nws_pkg::*;
();

    localparam int TABLE_DEPTH = 1024;
    localparam logic signed [30:0] LAT_MAX = 31'sd754974720;
    localparam logic signed [31:0] LON_MAX = 32'sd1509949440;

    typedef struct packed {
        logic [9:0] index;
        status_t    status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [30:0] latitude, [62:31] longitude
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [9:0] nearest_index
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // Predictor copy of the waypoint table
    longint  way_lat [TABLE_DEPTH];
    longint  way_lon [TABLE_DEPTH];
    int      way_count;
    answer_t answers_due [$];

    int errors;
    int burst_left;
    int hold_left;
    int stall_phase;

    nearest_waypoint_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // floor(a * b / 2^s), kept to 64 bits
    function automatic logic [63:0] mul_scaled(input logic [63:0] a, input logic [63:0] b,
                                               input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // Signed Q62 product, magnitude truncated
    function automatic longint q62_mul(input longint a, input longint b);
        logic [63:0] ua;
        logic [63:0] ub;
        longint      r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = longint'(mul_scaled(ua, ub, 62));
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Angle in degrees * 2^23 to a 32-bit turn phase
    function automatic logic [31:0] turn_phase(input longint x);
        longint r;
        logic [63:0] w;
        r = x % longint'(FULL_TURN);
        if (r < 0)
            r += longint'(FULL_TURN);
        w = (r * 64) / 45;
        return w[31:0];
    endfunction

    // Taylor series over the first octant
    function automatic void octant_trig(input logic [31:0] f, output logic [63:0] sn,
                                        output logic [63:0] cs);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] s;
        logic [63:0] c;
        t = mul_scaled({32'd0, f}, PI_Q62, 31);
        t2 = mul_scaled(t, t, 62);
        s = Q_ONE_U;
        c = Q_ONE_U;
        for (int k = 9; k >= 1; k--)
            s = Q_ONE_U - mul_scaled(t2, s, 62) / 64'((2 * k) * (2 * k + 1));
        for (int k = 10; k >= 1; k--)
            c = Q_ONE_U - mul_scaled(t2, c, 62) / 64'((2 * k - 1) * (2 * k));
        sn = mul_scaled(t, s, 62);
        cs = c;
    endfunction

    // Full-turn sine and cosine by octant and quadrant symmetry
    function automatic void phase_trig(input logic [31:0] ph, output longint sn,
                                       output longint cs);
        logic [63:0] a;
        logic [63:0] b;
        longint      sa;
        longint      ca;
        if (ph[29:0] < 30'h2000_0000)
        begin
            octant_trig({2'b00, ph[29:0]}, a, b);
            sa = longint'(a);
            ca = longint'(b);
        end
        else
        begin
            octant_trig(32'h4000_0000 - {2'b00, ph[29:0]}, a, b);
            sa = longint'(b);
            ca = longint'(a);
        end
        case (ph[31:30])
            2'd0:
            begin
                sn = sa;
                cs = ca;
            end
            2'd1:
            begin
                sn = ca;
                cs = -sa;
            end
            2'd2:
            begin
                sn = -sa;
                cs = -ca;
            end
            default:
            begin
                sn = -ca;
                cs = sa;
            end
        endcase
    endfunction

    // Apply one word to the table copy and queue the answer it causes
    function automatic void predict_word(input cmd_t cmd, input logic [30:0] lat_bits,
                                         input logic [31:0] lon_bits);
        longint  lat;
        longint  lon;
        longint  sq, cq, sp, cp, sd, cd, t1, t2, k, best;
        int      best_i;
        answer_t ans;
        lat = longint'($signed(lat_bits));
        lon = longint'($signed(lon_bits));
        case (cmd)
            CMD_ADD:
                if (way_count < TABLE_DEPTH)
                begin
                    way_lat[way_count] = lat;
                    way_lon[way_count] = lon;
                    way_count++;
                end
                else
                begin
                    ans.index = '0;
                    ans.status = STAT_FULL;
                    answers_due = {answers_due, ans};
                end
            CMD_CLEAR:
                way_count = 0;
            CMD_QUERY:
                if (way_count == 0)
                begin
                    ans.index = '0;
                    ans.status = STAT_EMPTY;
                    answers_due = {answers_due, ans};
                end
                else
                begin
                    phase_trig(turn_phase(lat), sq, cq);
                    best = 0;
                    best_i = 0;
                    for (int i = 0; i < way_count; i++)
                    begin
                        if (way_lat[i] == lat && way_lon[i] == lon)
                            k = Q_ONE;
                        else
                        begin
                            phase_trig(turn_phase(way_lat[i]), sp, cp);
                            phase_trig(turn_phase(way_lon[i] - lon), sd, cd);
                            t1 = q62_mul(sp, sq);
                            t2 = q62_mul(q62_mul(cp, cq), cd);
                            if (t2 >= 0 && t1 > Q_ONE - t2)
                                k = Q_ONE;
                            else
                                k = t1 + t2;
                            if (k > Q_ONE)
                                k = Q_ONE;
                            if (k < -Q_ONE)
                                k = -Q_ONE;
                        end
                        if (i == 0 || k > best)
                        begin
                            best = k;
                            best_i = i;
                        end
                    end
                    ans.index = best_i[9:0];
                    ans.status = STAT_FOUND;
                    answers_due = {answers_due, ans};
                end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Offer one word in bursts with random gaps, hold until taken
    task automatic send_word(input cmd_t cmd, input logic [30:0] lat, input logic [31:0] lon);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {1'b0, lon, lat};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_word(cmd, lat, lon);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [30:0] rand_lat();
        if ($urandom_range(0, 3) == 0)
            return 31'($urandom());
        return 31'($urandom_range(0, 2 * 754974720) - 754974720);
    endfunction

    function automatic logic [31:0] rand_lon();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($urandom_range(0, 32'd3019898880) - 32'd1509949440);
    endfunction

    // Extremes, exact match, ties, no-op, out-of-range angles, empty table
    task automatic test_directed();
        send_word(CMD_QUERY, 31'd0, 32'd0);
        send_word(CMD_NOP, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_ADD, LAT_MAX, -LON_MAX);
        send_word(CMD_ADD, -LAT_MAX, LON_MAX);
        send_word(CMD_ADD, 31'd0, 32'd0);
        send_word(CMD_ADD, 31'd0, 32'd0);
        send_word(CMD_ADD, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_ADD, 31'h4000_0000, 32'h8000_0000);
        send_word(CMD_QUERY, LAT_MAX, -LON_MAX);
        send_word(CMD_QUERY, 31'd0, 32'd0);
        send_word(CMD_QUERY, 31'd1, 32'd0);
        send_word(CMD_QUERY, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_QUERY, 31'h3FFF_FFFF, 32'h8000_0000);
        send_word(CMD_QUERY, -LAT_MAX, 32'h7FFF_FFFF);
        send_word(CMD_NOP, 31'd0, 32'd0);
        send_word(CMD_CLEAR, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_QUERY, 31'd5, 32'd5);
        settle();
    endtask

    // Long receiver hold while quick results pile up behind it
    task automatic test_backpressure();
        hold_left = 3000;
        for (int i = 0; i < 6; i++)
            send_word(CMD_QUERY, rand_lat(), rand_lon());
        send_word(CMD_ADD, rand_lat(), rand_lon());
        send_word(CMD_QUERY, rand_lat(), rand_lon());
        send_word(CMD_CLEAR, 31'd0, 32'd0);
        settle();
    endtask

    // Small tables, queries often near stored points
    task automatic test_random();
        int   pick;
        cmd_t cmd;
        logic [30:0] lat;
        logic [31:0] lon;
        for (int n = 0; n < 75; n++)
        begin
            pick = $urandom_range(0, 99);
            lat = rand_lat();
            lon = rand_lon();
            if (way_count >= 6 && pick < 45)
                cmd = CMD_CLEAR;
            else if (pick < 45)
                cmd = CMD_ADD;
            else if (pick < 85)
            begin
                cmd = CMD_QUERY;
                // Aim at a stored point, exactly or nearly
                if (way_count != 0 && $urandom_range(0, 2) != 0)
                begin
                    int j;
                    j = $urandom_range(0, way_count - 1);
                    lat = 31'(way_lat[j]) + 31'($urandom_range(0, 2) == 0 ? 0 :
                                                 $urandom_range(0, 4000) - 2000);
                    lon = 32'(way_lon[j]);
                end
            end
            else if (pick < 93)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_NOP;
            send_word(cmd, lat, lon);
        end
        settle();
    endtask

    // Check each result word against the oldest answer due; stall on a pattern
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answers_due.size() == 0)
                report_mismatch("unexpected result words", 1, 0);
            else
            begin
                want = answers_due.pop_front();
                if (m_axis_tdata[9:0] != want.index)
                    report_mismatch("nearest_index", m_axis_tdata[9:0], want.index);
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
            end
        end
        stall_phase = (stall_phase + 1) % 64;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_phase < 24)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_NOP;
        m_axis_tready = 1'b0;
        errors = 0;
        burst_left = 0;
        hold_left = 0;
        stall_phase = 0;
        way_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(12 * 4_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/nws_pkg.sv
hw/rtl/nws_mul.sv
hw/rtl/nws_div.sv
hw/rtl/nearest_waypoint_search.sv
verif/nearest_waypoint_search_test.sv
